[rtl/core/csv_numeric_stream_checker_core_defines.svh]
// assertion macros used by the checker file cnsc_checker.sv
`ifndef CSV_NUMERIC_STREAM_CHECKER_CORE_DEFINES_SVH
`define CSV_NUMERIC_STREAM_CHECKER_CORE_DEFINES_SVH

// same-cycle implication, masked while the reset is high
`define CNSC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cnsc assertion failed");

// next-cycle implication, masked while the given condition is high
`define CNSC_ASSERT_NEXT(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("cnsc assertion failed");

`endif

[rtl/core/cnsc_pkg.sv]
// ---------------------------------------------------------------------------
// cnsc_pkg
// shared widths, character codes and status codes of the csv checker
// ---------------------------------------------------------------------------
package cnsc_pkg;

  localparam int COUNT_WIDTH = 16;

  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_E_LO  = 8'h65;
  localparam logic [7:0] CHAR_E_UP  = 8'h45;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_UNEVEN   = 2'd1,
    ST_LONE_CR  = 2'd2,
    ST_BAD_CHAR = 2'd3
  } status_t;

  typedef logic [COUNT_WIDTH-1:0] count_t;

  // digits and e E + - , .
  function automatic logic char_allowed(input logic [7:0] c);
    return ((c >= CHAR_ZERO) && (c <= CHAR_NINE)) ||
           (c == CHAR_E_LO) || (c == CHAR_E_UP) || (c == CHAR_PLUS) ||
           (c == CHAR_MINUS) || (c == CHAR_COMMA) || (c == CHAR_DOT);
  endfunction

endpackage

[rtl/core/cnsc_if.sv]
// ---------------------------------------------------------------------------
// cnsc_in_if / cnsc_out_if
// valid/ready channels for input bytes and per-byte results
// ---------------------------------------------------------------------------
interface cnsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, char_in, first_byte, last_byte, input ready);
  modport sink   (input valid, char_in, first_byte, last_byte, output ready);
endinterface

interface cnsc_out_if;
  logic               valid;
  logic               ready;
  logic [7:0]         char_out;
  logic               char_valid;
  logic [1:0]         status;
  logic               file_done;
  cnsc_pkg::count_t   rows_total;
  cnsc_pkg::count_t   cols_total;
  cnsc_pkg::count_t   longest_field;

  modport source (output valid, char_out, char_valid, status, file_done, rows_total,
                  cols_total, longest_field, input ready);
  modport sink   (input valid, char_out, char_valid, status, file_done, rows_total,
                  cols_total, longest_field, output ready);
endinterface

[rtl/core/csv_numeric_stream_checker_core.sv]
// ---------------------------------------------------------------------------
// csv_numeric_stream_checker_core: input register, then result register
// throughput one byte per cycle while the result sink is ready, set by the single state update stage
// synchronous active-high reset clears both stages and all counters, no clearing pass
// ---------------------------------------------------------------------------
module csv_numeric_stream_checker_core (
  input  logic              clk,
  input  logic              rst,
  cnsc_in_if.sink           byte_in,
  cnsc_out_if.source        result
);

  // row-level state touched by a line end
  typedef struct packed {
    logic                first_row;
    cnsc_pkg::count_t    cols;
    cnsc_pkg::count_t    fields;
    cnsc_pkg::count_t    flen;
    cnsc_pkg::count_t    mx;
    cnsc_pkg::status_t   sts;
  } row_t;

  // saturating increment, stops at all ones
  function automatic cnsc_pkg::count_t sat_inc(input cnsc_pkg::count_t v);
    return (v == '1) ? v : v + cnsc_pkg::count_t'(1'b1);
  endfunction

  // first error wins
  function automatic cnsc_pkg::status_t flag(input cnsc_pkg::status_t cur,
                                             input cnsc_pkg::status_t code);
    return (cur == cnsc_pkg::ST_OK) ? code : cur;
  endfunction

  // finish a row: complete the field count, fix it or compare, close the field
  function automatic row_t close_row(input row_t r);
    row_t             o;
    cnsc_pkg::count_t n;
    o = r;
    n = (r.fields != '0) ? sat_inc(r.fields) : r.fields;
    if (r.first_row) begin
      o.first_row = 1'b0;
      o.cols      = n;
    end else if (n != r.cols) begin
      o.sts = flag(r.sts, cnsc_pkg::ST_UNEVEN);
    end
    o.fields = '0;
    if (r.flen > r.mx) begin
      o.mx = r.flen;
    end
    o.flen = '0;
    return o;
  endfunction

  // input register stage
  logic       s1_valid;
  logic [7:0] s1_char;
  logic       s1_first;
  logic       s1_last;
  logic       s1_adv;

  // file state
  logic              cr_pending;
  logic              in_first_row;
  cnsc_pkg::count_t  cols_expected;
  cnsc_pkg::count_t  fields_in_row;
  cnsc_pkg::count_t  newline_count;
  cnsc_pkg::count_t  max_field_len;
  cnsc_pkg::count_t  field_len;
  cnsc_pkg::status_t sticky_status;

  logic              cr_pending_next;
  row_t              row_next;
  cnsc_pkg::count_t  newline_count_next;
  logic [7:0]        cout_next;
  logic              cvalid_next;

  // result register stage
  logic out_valid;

  // the result register frees up when it is taken or empty
  assign s1_adv        = s1_valid && (!out_valid || result.ready);
  assign byte_in.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (byte_in.ready) begin
      s1_valid <= byte_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_in.valid && byte_in.ready) begin
      s1_char  <= byte_in.char_in;
      s1_first <= byte_in.first_byte;
      s1_last  <= byte_in.last_byte;
    end
  end

  // per-byte state update, applied in this order: lone cr check,
  // byte processing, then the end-of-file checks
  always_comb begin
    row_t             r;
    logic             cp;
    cnsc_pkg::count_t nl;

    if (s1_first) begin
      // a first byte starts from reset values
      cp = 1'b0;
      nl = '0;
      r  = '{first_row: 1'b1, cols: '0, fields: '0, flen: '0, mx: '0,
             sts: cnsc_pkg::ST_OK};
    end else begin
      cp = cr_pending;
      nl = newline_count;
      r  = '{first_row: in_first_row, cols: cols_expected, fields: fields_in_row,
             flen: field_len, mx: max_field_len, sts: sticky_status};
    end

    if (cp && (s1_char != cnsc_pkg::CHAR_LF)) begin
      r.sts = flag(r.sts, cnsc_pkg::ST_LONE_CR);
    end

    cout_next   = s1_char;
    cvalid_next = 1'b1;
    if (s1_char == cnsc_pkg::CHAR_CR) begin
      // cr is swallowed and waits for its lf
      cp          = 1'b1;
      cvalid_next = 1'b0;
      cout_next   = 8'h00;
    end else if (s1_char == cnsc_pkg::CHAR_LF) begin
      nl        = sat_inc(nl);
      r         = close_row(r);
      cp        = 1'b0;
      cout_next = cnsc_pkg::CHAR_COMMA;
    end else begin
      cp = 1'b0;
      if (s1_char == cnsc_pkg::CHAR_COMMA) begin
        r.fields = sat_inc(r.fields);
        if (r.flen > r.mx) begin
          r.mx = r.flen;
        end
        r.flen = '0;
      end else begin
        r.flen = sat_inc(r.flen);
        if (!cnsc_pkg::char_allowed(s1_char)) begin
          r.sts = flag(r.sts, cnsc_pkg::ST_BAD_CHAR);
        end
      end
    end

    // end of file acts as an uncounted line end
    if (s1_last) begin
      if (cp) begin
        r.sts = flag(r.sts, cnsc_pkg::ST_LONE_CR);
      end
      cp = 1'b0;
      r  = close_row(r);
    end

    cr_pending_next    = cp;
    row_next           = r;
    newline_count_next = nl;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cr_pending    <= 1'b0;
      in_first_row  <= 1'b1;
      cols_expected <= '0;
      fields_in_row <= '0;
      newline_count <= '0;
      max_field_len <= '0;
      field_len     <= '0;
      sticky_status <= cnsc_pkg::ST_OK;
    end else if (s1_adv) begin
      cr_pending    <= cr_pending_next;
      in_first_row  <= row_next.first_row;
      cols_expected <= row_next.cols;
      fields_in_row <= row_next.fields;
      newline_count <= newline_count_next;
      max_field_len <= row_next.mx;
      field_len     <= row_next.flen;
      sticky_status <= row_next.sts;
    end
  end

  // result register, holds while the sink stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      result.char_out      <= cout_next;
      result.char_valid    <= cvalid_next;
      result.status        <= row_next.sts;
      result.file_done     <= s1_last;
      result.rows_total    <= sat_inc(newline_count_next);
      result.cols_total    <= row_next.cols;
      result.longest_field <= row_next.mx;
    end
  end

  assign result.valid = out_valid;

endmodule

[rtl/core/cnsc_checker.sv]
// ---------------------------------------------------------------------------
// cnsc_checker
// port-level assertions on the csv checker, bound to csv_numeric_stream_checker_core
// ---------------------------------------------------------------------------
`include "csv_numeric_stream_checker_core_defines.svh"

module cnsc_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   res_valid,
  input logic                   res_ready,
  input logic [7:0]             char_out,
  input logic                   char_valid,
  input cnsc_pkg::count_t       rows_total
);

  // nothing comes out straight after reset
  `CNSC_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !res_valid)

  // a swallowed cr shows a zero byte
  `CNSC_ASSERT_NOW(a_cr_zero, clk, rst, res_valid && !char_valid, char_out == 8'h00)

  // stored bytes never carry cr or lf
  `CNSC_ASSERT_NOW(a_no_line_end, clk, rst, res_valid && char_valid,
                   (char_out != cnsc_pkg::CHAR_CR) && (char_out != cnsc_pkg::CHAR_LF))

  // row count is at least one on every result
  `CNSC_ASSERT_NOW(a_rows_nonzero, clk, rst, res_valid, rows_total != '0)

  // a stalled result holds
  `CNSC_ASSERT_NEXT(a_stall_hold, clk, rst, res_valid && !res_ready,
                    res_valid && $stable(char_out) && $stable(rows_total))

endmodule

bind csv_numeric_stream_checker_core cnsc_checker u_cnsc_checker (
  .clk        (clk),
  .rst        (rst),
  .res_valid  (result.valid),
  .res_ready  (result.ready),
  .char_out   (result.char_out),
  .char_valid (result.char_valid),
  .rows_total (result.rows_total)
);
